### src/assert_macros.svh
// Assertion helpers shared by the RTL. All checks run on clk_i and are
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in the same cycle as the consequent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/eulrot_pkg.sv
package eulrot_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_WIDTH_DEF = 16;

  localparam int NUM_AXES    = 3;
  localparam int AXIS_W      = 2;
  localparam int CFG_INDEX_W = 2;

  // Register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_Z = 2'd2;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam int FRAC_BITS    = 30;
  localparam int TRIG_W       = 32;
  localparam int CORDIC_W     = 33;
  localparam int PHASE_W      = 32;
  localparam int CORDIC_STEPS = 28;
  localparam int STEP_W       = 5;

  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 33'sd652032874;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_t;

  typedef struct packed {
    logic busy;
    logic cfg_ready;
  } status_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [TRIG_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [TRIG_W-1:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      5'd24:   r = 32'h00000029;
      5'd25:   r = 32'h00000014;
      5'd26:   r = 32'h0000000A;
      5'd27:   r = 32'h00000005;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### src/euler_xyz_point_rotation_top.sv
// Euler X-Y-Z point rotation.
// Configuration channel: cfg_valid_i/cfg_ready_o with cfg_index_i selecting
// angle_about_x (0), angle_about_y (1) or angle_about_z (2); higher indexes
// are ignored. Each write reruns a shared 28-step CORDIC for that angle, so
// the block holds busy high and cfg_ready_o low until the new sin/cos is stored.
// Command channel: a point on in_x_i/in_y_i/in_z_i is taken at a clock edge
// with start high and busy low. One point per cycle is sustained while busy
// is low; the depth of the pipeline (an input register, then a multiply and
// a round/saturate stage per axis) sets latency only.
// Each rotated point appears on out_x_o/out_y_o/out_z_o with out_valid_o
// high once it has passed the input register and then the X, Y and Z axis
// stages. The receiver cannot stall, so the pipeline never holds and never
// drops a point. Reset clears the angles to zero and empties the pipeline;
// busy stays high after reset until all three angles have been computed.
`include "assert_macros.svh"

module euler_xyz_point_rotation_top #(
  parameter int COORD_WIDTH = eulrot_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = eulrot_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [eulrot_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [ANGLE_WIDTH-1:0]             cfg_data_i,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_WIDTH-1:0]      in_x_i,
  input  logic signed [COORD_WIDTH-1:0]      in_y_i,
  input  logic signed [COORD_WIDTH-1:0]      in_z_i,
  output logic                               out_valid_o,
  output logic signed [COORD_WIDTH-1:0]      out_x_o,
  output logic signed [COORD_WIDTH-1:0]      out_y_o,
  output logic signed [COORD_WIDTH-1:0]      out_z_o
);
  import eulrot_pkg::*;

  status_t status;
  trig_t [NUM_AXES-1:0] trig;
  logic accept;
  logic angle_wr;
  logic in_valid_q;
  logic signed [COORD_WIDTH-1:0] x0_q, y0_q, z0_q;
  logic v1, v2;
  logic signed [COORD_WIDTH-1:0] x1, y1, z1, x2, y2, z2;

  eulrot_trig #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_trig (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .status_o   (status),
    .trig_o     (trig)
  );

  assign cfg_ready_o = status.cfg_ready;
  assign busy        = status.busy;
  assign accept      = start && !status.busy;
  assign angle_wr    = cfg_valid_i && cfg_ready_o &&
                       ((cfg_index_i == REG_ANGLE_X) || (cfg_index_i == REG_ANGLE_Y) ||
                        (cfg_index_i == REG_ANGLE_Z));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x0_q <= in_x_i;
      y0_q <= in_y_i;
      z0_q <= in_z_i;
    end
  end

  // About X: (y, z) rotate, x passes
  eulrot_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .trig_i (trig[AXIS_X]),
    .valid_i(in_valid_q),
    .u_i    (y0_q),
    .v_i    (z0_q),
    .w_i    (x0_q),
    .valid_o(v1),
    .u_o    (y1),
    .v_o    (z1),
    .w_o    (x1)
  );

  // About Y: (z, x) rotate, y passes
  eulrot_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .trig_i (trig[AXIS_Y]),
    .valid_i(v1),
    .u_i    (z1),
    .v_i    (x1),
    .w_i    (y1),
    .valid_o(v2),
    .u_o    (z2),
    .v_o    (x2),
    .w_o    (y2)
  );

  // About Z: (x, y) rotate, z passes
  eulrot_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .trig_i (trig[AXIS_Z]),
    .valid_i(v2),
    .u_i    (x2),
    .v_i    (y2),
    .w_i    (z2),
    .valid_o(out_valid_o),
    .u_o    (out_x_o),
    .v_o    (out_y_o),
    .w_o    (out_z_o)
  );

  `ASSERT_IMPLIES(a_result_follows_beat, accept, ##7 out_valid_o, "accepted beat lost in pipeline")
  `ASSERT_IMPLIES(a_result_has_source, out_valid_o, $past(accept, 7), "result without accepted beat")
  `ASSERT_NEXT(a_cfg_sets_busy, angle_wr, busy, "angle write did not start trig update")

endmodule

### src/eulrot_trig.sv
module eulrot_trig #(
  parameter int ANGLE_WIDTH = eulrot_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_valid_i,
  input  logic [eulrot_pkg::CFG_INDEX_W-1:0]        cfg_index_i,
  input  logic [ANGLE_WIDTH-1:0]                    cfg_data_i,
  output eulrot_pkg::status_t                       status_o,
  output eulrot_pkg::trig_t [eulrot_pkg::NUM_AXES-1:0] trig_o
);
  import eulrot_pkg::*;

  localparam int PHASE_SHIFT = PHASE_W - ANGLE_WIDTH;
  localparam logic signed [CORDIC_W-1:0] ONE_POS = CORDIC_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [CORDIC_W-1:0] ONE_NEG = -ONE_POS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [NUM_AXES-1:0] dirty_q, dirty_d;
  logic [AXIS_W-1:0] sel_q, sel_d, pick;
  logic [STEP_W-1:0] step_q, step_d;
  logic [1:0] quad_q, quad_d;
  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [CORDIC_W-1:0] dx, dy, atan_s;
  logic [ANGLE_WIDTH-1:0] angle_q [NUM_AXES];
  logic [PHASE_W-1:0] phase;
  logic signed [TRIG_W-1:0] c_clamp, s_clamp;
  trig_t trig_new;
  trig_t [NUM_AXES-1:0] trig_q;
  logic cfg_ready, cfg_write;

  function automatic logic signed [TRIG_W-1:0] clamp_one(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    r = v;
    if (v > ONE_POS) r = ONE_POS;
    if (v < ONE_NEG) r = ONE_NEG;
    return r[TRIG_W-1:0];
  endfunction

  assign cfg_ready = (state_q == ST_IDLE) && (dirty_q == '0);
  assign cfg_write = cfg_valid_i && cfg_ready;
  assign status_o.cfg_ready = cfg_ready;
  assign status_o.busy = !cfg_ready;
  assign trig_o = trig_q;

  // Lowest pending axis goes first
  always_comb begin
    pick = AXIS_X;
    for (int i = NUM_AXES - 1; i >= 0; i--) begin
      if (dirty_q[i]) pick = AXIS_W'(i);
    end
  end

  assign phase  = PHASE_W'(angle_q[pick]) << PHASE_SHIFT;
  assign dx     = y_q >>> step_q;
  assign dy     = x_q >>> step_q;
  assign atan_s = CORDIC_W'(signed'(atan_turn(step_q)));

  always_comb begin
    state_d = state_q;
    dirty_d = dirty_q;
    sel_d   = sel_q;
    step_d  = step_q;
    quad_d  = quad_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    case (state_q)
      ST_IDLE: begin
        if (|dirty_q) begin
          sel_d        = pick;
          dirty_d[pick] = 1'b0;
          x_d          = CORDIC_X0;
          y_d          = '0;
          z_d          = CORDIC_W'({1'b0, phase[PHASE_W-3:0]});
          quad_d       = phase[PHASE_W-1:PHASE_W-2];
          step_d       = '0;
          state_d      = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!z_q[CORDIC_W-1]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_s;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_s;
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) state_d = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (cfg_write) begin
      case (cfg_index_i)
        REG_ANGLE_X: dirty_d[AXIS_X] = 1'b1;
        REG_ANGLE_Y: dirty_d[AXIS_Y] = 1'b1;
        REG_ANGLE_Z: dirty_d[AXIS_Z] = 1'b1;
        default: ;
      endcase
    end
  end

  assign c_clamp = clamp_one(x_q);
  assign s_clamp = clamp_one(y_q);

  // Fold the first-quadrant result into the quadrant of the phase
  always_comb begin
    case (quad_q)
      2'd0: begin
        trig_new.cos_v = c_clamp;
        trig_new.sin_v = s_clamp;
      end
      2'd1: begin
        trig_new.cos_v = -s_clamp;
        trig_new.sin_v = c_clamp;
      end
      2'd2: begin
        trig_new.cos_v = -c_clamp;
        trig_new.sin_v = -s_clamp;
      end
      default: begin
        trig_new.cos_v = s_clamp;
        trig_new.sin_v = -c_clamp;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dirty_q <= '1;
      step_q  <= '0;
      sel_q   <= AXIS_X;
      for (int i = 0; i < NUM_AXES; i++) angle_q[i] <= '0;
    end else begin
      state_q <= state_d;
      dirty_q <= dirty_d;
      step_q  <= step_d;
      sel_q   <= sel_d;
      if (cfg_write) begin
        case (cfg_index_i)
          REG_ANGLE_X: angle_q[AXIS_X] <= cfg_data_i;
          REG_ANGLE_Y: angle_q[AXIS_Y] <= cfg_data_i;
          REG_ANGLE_Z: angle_q[AXIS_Z] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q <= quad_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    if (state_q == ST_DONE) trig_q[sel_q] <= trig_new;
  end

endmodule

### src/eulrot_axis.sv
// One plane rotation: u' = c*u - s*v, v' = s*u + c*v, w passes through.
module eulrot_axis #(
  parameter int COORD_WIDTH = eulrot_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  eulrot_pkg::trig_t             trig_i,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] u_i,
  input  logic signed [COORD_WIDTH-1:0] v_i,
  input  logic signed [COORD_WIDTH-1:0] w_i,
  output logic                          valid_o,
  output logic signed [COORD_WIDTH-1:0] u_o,
  output logic signed [COORD_WIDTH-1:0] v_o,
  output logic signed [COORD_WIDTH-1:0] w_o
);
  import eulrot_pkg::*;

  localparam int PW = TRIG_W + COORD_WIDTH;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] RND = SW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic signed [PW-1:0] pcu_q, psv_q, psu_q, pcv_q;
  logic signed [COORD_WIDTH-1:0] w_m_q;
  logic valid_m_q, valid_a_q;
  logic signed [SW-1:0] sum_u, sum_v;
  logic signed [COORD_WIDTH-1:0] u_d, v_d, u_q, v_q, w_a_q;

  function automatic logic signed [COORD_WIDTH-1:0] round_sat(input logic signed [SW-1:0] acc);
    logic signed [SW-1:0] sh;
    logic signed [SW-1:0] r;
    sh = acc >>> FRAC_BITS;
    r = sh;
    if (sh > SAT_HI) r = SAT_HI;
    if (sh < SAT_LO) r = SAT_LO;
    return r[COORD_WIDTH-1:0];
  endfunction

  // Multiply stage
  always_ff @(posedge clk_i) begin
    pcu_q <= PW'(trig_i.cos_v) * PW'(u_i);
    psv_q <= PW'(trig_i.sin_v) * PW'(v_i);
    psu_q <= PW'(trig_i.sin_v) * PW'(u_i);
    pcv_q <= PW'(trig_i.cos_v) * PW'(v_i);
    w_m_q <= w_i;
  end

  assign sum_u = SW'(pcu_q) - SW'(psv_q) + RND;
  assign sum_v = SW'(psu_q) + SW'(pcv_q) + RND;
  assign u_d   = round_sat(sum_u);
  assign v_d   = round_sat(sum_v);

  // Round and saturate stage
  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    v_q   <= v_d;
    w_a_q <= w_m_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_m_q <= 1'b0;
      valid_a_q <= 1'b0;
    end else begin
      valid_m_q <= valid_i;
      valid_a_q <= valid_m_q;
    end
  end

  assign valid_o = valid_a_q;
  assign u_o     = u_q;
  assign v_o     = v_q;
  assign w_o     = w_a_q;

endmodule
